@@ sv/thmhe_pkg.sv @@
// ---------------------------------------------------------------------------
// thmhe_pkg: shared types and constants
// Word formats, status and kind codes, CSR indexes, MAC control bundle.
// ---------------------------------------------------------------------------
package thmhe_pkg;

   localparam int COORD_BITS  = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int ERR_BITS    = 24;
   localparam int CSR_BITS    = 11;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   localparam logic [CSR_BITS-1:0] MAP_SIDE_RESET = 11'd1024;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_DEGENERATE = 2'd1,
      STATUS_OUTSIDE    = 2'd2
   } status_type;

   typedef struct packed {
      logic                   kind;
      logic [COORD_BITS-1:0]  write_x;
      logic [COORD_BITS-1:0]  write_y;
      logic [SAMPLE_BITS-1:0] height;
      logic [COORD_BITS-1:0]  vertex0_x;
      logic [COORD_BITS-1:0]  vertex0_y;
      logic [COORD_BITS-1:0]  vertex1_x;
      logic [COORD_BITS-1:0]  vertex1_y;
      logic [COORD_BITS-1:0]  vertex2_x;
      logic [COORD_BITS-1:0]  vertex2_y;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] best_x;
      logic [COORD_BITS-1:0] best_y;
      logic [ERR_BITS-1:0]   error_q8;
      status_type            status;
   } rsp_word_type;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic en;
      logic clr;
      logic sub;
   } mac_ctl_type;

endpackage

@@ sv/thmhe_ram.sv @@
// ---------------------------------------------------------------------------
// thmhe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module thmhe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1048576
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/thmhe_mac.sv @@
// ---------------------------------------------------------------------------
// thmhe_mac: shared signed multiply-accumulate unit
// acc <= (clr ? 0 : acc) +/- a * b, one product per cycle while ctl.en is high.
// ---------------------------------------------------------------------------
module thmhe_mac #(
   parameter int OAW  = 17,
   parameter int OBW  = 23,
   parameter int ACCW = 42
) (
   input  logic                    clock,
   input  thmhe_pkg::mac_ctl_type  ctl,
   input  logic signed [OAW-1:0]   op_a,
   input  logic signed [OBW-1:0]   op_b,
   output logic signed [ACCW-1:0]  acc
);

   logic signed [OAW+OBW-1:0] prod;
   logic signed [ACCW-1:0]    prod_x;
   logic signed [ACCW-1:0]    base;
   logic signed [ACCW-1:0]    acc_ff;
   logic signed [ACCW-1:0]    acc_in;

   assign prod   = op_a * op_b;
   assign prod_x = ACCW'(prod);
   assign base   = ctl.clr ? '0 : acc_ff;
   assign acc_in = ctl.sub ? (base - prod_x) : (base + prod_x);

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

@@ sv/thmhe_div.sv @@
// ---------------------------------------------------------------------------
// thmhe_div: bit-serial restoring divider
// One quotient bit per cycle; the quotient must fit in QW bits.
// ---------------------------------------------------------------------------
module thmhe_div #(
   parameter int NUMW = 50,
   parameter int DW   = 23,
   parameter int QW   = 25
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] num,
   input  logic [DW-1:0]   den,
   output logic            done,
   output logic [QW-1:0]   quot
);

   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff,  rem_in;
   logic [DW-1:0] den_ff,  den_in;
   logic [QW-1:0] low_ff,  low_in;   // numerator low bits out, quotient bits in
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          run_ff,  run_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num[QW+DW-1:QW];
         low_in = num[QW-1:0];
         den_in = den;
         cnt_in = CW'(QW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            low_in = {low_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            low_in = {low_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = low_ff;

endmodule

@@ sv/triangle_max_height_error.sv @@
// ---------------------------------------------------------------------------
// triangle_max_height_error: worst height error inside a triangle
// Heightmap store plus a sequencer that rasterizes a triangle's bounding box
// and finds the first pixel with the greatest plane-vs-sample error.
// ---------------------------------------------------------------------------
// A write word (kind 0) stores one sample; busy never rises and no response is
// produced. A query word (kind 1) raises busy until its single response word
// is strobed on rsp_valid for one cycle, and busy is low in that cycle; the
// response cannot be held off, so capture it when rsp_valid is high.
// A query checks and sizes the triangle, fetches the vertex samples, then for
// every pixel of the bounding box evaluates the edge functions and, when the
// pixel lies inside, computes its plane error. The per-pixel work runs on the
// single shared multiplier (six products for the edge functions, four for the
// plane error) and on the bit-serial divider that scales the error to 8
// fraction bits. Bad vertices and degenerate or clockwise triangles answer
// before any vertex sample is fetched.
// The store is not cleared: a query must only touch samples already written.
// Configure map_width / map_height only while busy is low.
// ---------------------------------------------------------------------------
module triangle_max_height_error #(
   parameter int MAX_SIDE    = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  thmhe_pkg::req_word_type           req_word,
   output logic                              rsp_valid,
   output thmhe_pkg::rsp_word_type           rsp_word,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [thmhe_pkg::CSR_BITS-1:0]    csr_wdata
);

   localparam int CB    = thmhe_pkg::COORD_BITS;
   localparam int AXW   = $clog2(MAX_SIDE);            // per-axis address bits
   localparam int DEPTH = 2 ** (2 * AXW);
   localparam int ADW   = 2 * AXW;
   localparam int DFW   = CB + 1;                      // coordinate difference
   localparam int EW    = 2 * DFW + 1;                 // edge function value
   localparam int OAW   = (HEIGHT_BITS + 1 > DFW) ? HEIGHT_BITS + 1 : DFW;
   localparam int ACCW  = OAW + EW + 2;
   localparam int NUMW  = ACCW + 8;
   localparam int QW    = HEIGHT_BITS + 9;
   localparam int SW    = 13;                          // holds MAX_SIDE
   localparam logic [SW-1:0] MAX_SIDE_V = SW'(MAX_SIDE);
   localparam int EB    = thmhe_pkg::ERR_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_AREA, ST_AREA_END, ST_HREAD, ST_EDGE, ST_INSIDE,
      ST_ERR, ST_DIV_GO, ST_DIV_WAIT, ST_NEXT, ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [2:0]               step_ff, step_in;
   logic [CB-1:0]            vx_ff [3];
   logic [CB-1:0]            vx_in [3];
   logic [CB-1:0]            vy_ff [3];
   logic [CB-1:0]            vy_in [3];
   logic [HEIGHT_BITS-1:0]   h_ff [3];
   logic [HEIGHT_BITS-1:0]   h_in [3];
   logic signed [EW-1:0]     w_ff [3];
   logic signed [EW-1:0]     w_in [3];
   logic signed [EW-1:0]     a_ff, a_in;
   logic [CB-1:0]            x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [CB-1:0]            px_ff, px_in, py_ff, py_in;
   logic [EB-1:0]            best_ff, best_in;
   logic [CB-1:0]            bx_ff, bx_in, by_ff, by_in;
   logic [CB:0]              map_w_ff, map_w_in, map_h_ff, map_h_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   thmhe_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;

   // shared arithmetic
   thmhe_pkg::mac_ctl_type   mac_ctl;
   logic signed [OAW-1:0]    op_a;
   logic signed [EW-1:0]     op_b;
   logic signed [ACCW-1:0]   acc;
   logic [ACCW-1:0]          mag;
   logic [NUMW-1:0]          div_num;
   logic                     div_start, div_done;
   logic [QW-1:0]            quot;
   logic [QW+EB-1:0]         quot_x;
   logic [EB-1:0]            err_sat;

   // store ports
   logic                     ram_we, ram_re;
   logic [ADW-1:0]           ram_waddr, ram_raddr;
   logic [HEIGHT_BITS-1:0]   ram_wdata, ram_rdata;

   // edge operand selection
   logic [1:0]               edge_sel;
   logic [CB-1:0]            ax, ay, bxv, byv, cx, cy;
   logic signed [DFW-1:0]    dif_1, dif_2;

   logic                     accept, bad_vertex, on_vertex;
   logic [SW-1:0]            eff_w, eff_h;

   function automatic logic signed [DFW-1:0] cdiff(input logic [CB-1:0] p,
                                                   input logic [CB-1:0] q);
      cdiff = $signed({1'b0, p}) - $signed({1'b0, q});
   endfunction

   function automatic logic [ADW-1:0] cell_addr(input logic [CB-1:0] x,
                                                input logic [CB-1:0] y);
      cell_addr = {AXW'(y), AXW'(x)};
   endfunction

   function automatic logic [CB-1:0] min3(input logic [CB-1:0] p,
                                          input logic [CB-1:0] q,
                                          input logic [CB-1:0] r);
      logic [CB-1:0] m;
      m = (p < q) ? p : q;
      min3 = (m < r) ? m : r;
   endfunction

   function automatic logic [CB-1:0] max3(input logic [CB-1:0] p,
                                          input logic [CB-1:0] q,
                                          input logic [CB-1:0] r);
      logic [CB-1:0] m;
      m = (p > q) ? p : q;
      max3 = (m > r) ? m : r;
   endfunction

   assign accept = start && !busy;

   // writes go straight to the store; out-of-store positions are dropped
   assign ram_we    = accept && (req_word.kind == thmhe_pkg::KIND_WRITE) &&
                      (SW'(req_word.write_x) < MAX_SIDE_V) &&
                      (SW'(req_word.write_y) < MAX_SIDE_V);
   assign ram_waddr = cell_addr(req_word.write_x, req_word.write_y);
   assign ram_wdata = HEIGHT_BITS'(req_word.height);

   thmhe_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   thmhe_mac #(
      .OAW  (OAW),
      .OBW  (EW),
      .ACCW (ACCW)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // error numerator: |diff| * 256 + a/2, divided by a
   assign mag     = acc[ACCW-1] ? ACCW'(-acc) : ACCW'(acc);
   assign div_num = {mag, 8'd0} + NUMW'(a_ff[EW-1:1]);

   thmhe_div #(
      .NUMW (NUMW),
      .DW   (EW),
      .QW   (QW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (a_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign quot_x  = (QW + EB)'(quot);
   assign err_sat = (|quot_x[QW+EB-1:EB]) ? '1 : quot_x[EB-1:0];

   // clamp map size to the store side
   assign eff_w = (SW'(map_w_ff) > MAX_SIDE_V) ? MAX_SIDE_V : SW'(map_w_ff);
   assign eff_h = (SW'(map_h_ff) > MAX_SIDE_V) ? MAX_SIDE_V : SW'(map_h_ff);

   always_comb begin
      bad_vertex = 1'b0;
      on_vertex  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if ((SW'(vx_ff[i]) >= eff_w) || (SW'(vy_ff[i]) >= eff_h)) begin
            bad_vertex = 1'b1;
         end
         if ((bx_ff == vx_ff[i]) && (by_ff == vy_ff[i])) begin
            on_vertex = 1'b1;
         end
      end
   end

   // edge(A, B, C) = (Bx-Cx)*(Ay-Cy) - (By-Cy)*(Ax-Cx)
   // 0: area (v0,v1,v2); 1: w0 (v1,v2,p); 2: w1 (v2,v0,p); 3: w2 (v0,v1,p)
   assign edge_sel = (state_ff == ST_AREA) ? 2'd0 : (step_ff[2:1] + 2'd1);

   always_comb begin
      unique case (edge_sel)
         2'd0: begin
            ax = vx_ff[0]; ay = vy_ff[0]; bxv = vx_ff[1]; byv = vy_ff[1];
            cx = vx_ff[2]; cy = vy_ff[2];
         end
         2'd1: begin
            ax = vx_ff[1]; ay = vy_ff[1]; bxv = vx_ff[2]; byv = vy_ff[2];
            cx = px_ff;    cy = py_ff;
         end
         2'd2: begin
            ax = vx_ff[2]; ay = vy_ff[2]; bxv = vx_ff[0]; byv = vy_ff[0];
            cx = px_ff;    cy = py_ff;
         end
         default: begin
            ax = vx_ff[0]; ay = vy_ff[0]; bxv = vx_ff[1]; byv = vy_ff[1];
            cx = px_ff;    cy = py_ff;
         end
      endcase
      dif_1 = step_ff[0] ? cdiff(byv, cy) : cdiff(bxv, cx);
      dif_2 = step_ff[0] ? cdiff(ax, cx)  : cdiff(ay, cy);
   end

   // operand routing and store reads
   always_comb begin
      mac_ctl   = '0;
      op_a      = OAW'(dif_1);
      op_b      = EW'(dif_2);
      ram_re    = 1'b0;
      ram_raddr = cell_addr(px_ff, py_ff);
      div_start = 1'b0;
      unique case (state_ff)
         ST_AREA, ST_EDGE: begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = !step_ff[0];
            mac_ctl.sub = step_ff[0];
            if ((state_ff == ST_EDGE) && (step_ff == 3'd0)) begin
               ram_re = 1'b1;
            end
         end
         ST_HREAD: begin
            unique case (step_ff)
               3'd0: begin
                  ram_re    = 1'b1;
                  ram_raddr = cell_addr(vx_ff[0], vy_ff[0]);
               end
               3'd1: begin
                  ram_re    = 1'b1;
                  ram_raddr = cell_addr(vx_ff[1], vy_ff[1]);
               end
               3'd2: begin
                  ram_re    = 1'b1;
                  ram_raddr = cell_addr(vx_ff[2], vy_ff[2]);
               end
               default: begin
                  ram_re = 1'b0;
               end
            endcase
         end
         ST_ERR: begin
            // h0*w0 + h1*w1 + h2*w2 - H*a
            mac_ctl.en = 1'b1;
            unique case (step_ff)
               3'd0: begin
                  mac_ctl.clr = 1'b1;
                  op_a = $signed(OAW'(h_ff[0]));
                  op_b = w_ff[0];
               end
               3'd1: begin
                  op_a = $signed(OAW'(h_ff[1]));
                  op_b = w_ff[1];
               end
               3'd2: begin
                  op_a = $signed(OAW'(h_ff[2]));
                  op_b = w_ff[2];
               end
               default: begin
                  mac_ctl.sub = 1'b1;
                  op_a = $signed(OAW'(ram_rdata));
                  op_b = a_ff;
               end
            endcase
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
         end
         default: begin
            mac_ctl = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      best_in      = best_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      map_w_in     = map_w_ff;
      map_h_in     = map_h_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      if (csr_we) begin
         unique case (csr_index)
            thmhe_pkg::CSR_MAP_WIDTH:  map_w_in = csr_wdata;
            thmhe_pkg::CSR_MAP_HEIGHT: map_h_in = csr_wdata;
            default:                   map_w_in = map_w_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.kind == thmhe_pkg::KIND_QUERY)) begin
               vx_in[0] = req_word.vertex0_x;
               vy_in[0] = req_word.vertex0_y;
               vx_in[1] = req_word.vertex1_x;
               vy_in[1] = req_word.vertex1_y;
               vx_in[2] = req_word.vertex2_x;
               vy_in[2] = req_word.vertex2_y;
               best_in  = '0;
               bx_in    = '0;
               by_in    = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (bad_vertex) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{best_x: '0, best_y: '0, error_q8: '0,
                                status: thmhe_pkg::STATUS_OUTSIDE};
               state_in     = ST_IDLE;
            end else begin
               step_in  = 3'd0;
               state_in = ST_AREA;
            end
         end
         ST_AREA: begin
            step_in = step_ff + 3'd1;
            if (step_ff[0]) begin
               state_in = ST_AREA_END;
            end
         end
         ST_AREA_END: begin
            a_in  = acc[EW-1:0];
            x0_in = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
            x1_in = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
            y0_in = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
            y1_in = max3(vy_ff[0], vy_ff[1], vy_ff[2]);
            step_in = 3'd0;
            if (acc == '0) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{best_x: '0, best_y: '0, error_q8: '0,
                                status: thmhe_pkg::STATUS_DEGENERATE};
               state_in     = ST_IDLE;
            end else if (acc[ACCW-1]) begin
               // clockwise: nothing passes the inside test
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{best_x: '0, best_y: '0, error_q8: '0,
                                status: thmhe_pkg::STATUS_OK};
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            // read data is registered, so it arrives in the cycle after its address
            unique case (step_ff)
               3'd1:    h_in[0] = ram_rdata;
               3'd2:    h_in[1] = ram_rdata;
               3'd3:    h_in[2] = ram_rdata;
               default: h_in[0] = h_ff[0];
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               px_in    = x0_ff;
               py_in    = y0_ff;
               step_in  = 3'd0;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            unique case (step_ff)
               3'd2:    w_in[0] = acc[EW-1:0];
               3'd4:    w_in[1] = acc[EW-1:0];
               default: w_in[0] = w_ff[0];
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = ST_INSIDE;
            end
         end
         ST_INSIDE: begin
            w_in[2] = acc[EW-1:0];
            step_in = 3'd0;
            if (w_ff[0][EW-1] || w_ff[1][EW-1] || acc[ACCW-1]) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               // strict compare keeps the first pixel in raster order
               if (err_sat > best_ff) begin
                  best_in = err_sat;
                  bx_in   = px_ff;
                  by_in   = py_ff;
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            step_in  = 3'd0;
            state_in = ST_EDGE;
            if (px_ff == x1_ff) begin
               px_in = x0_ff;
               if (py_ff == y1_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  py_in = py_ff + 1'b1;
               end
            end else begin
               px_in = px_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = '{best_x: bx_ff, best_y: by_ff,
                             error_q8: on_vertex ? '0 : best_ff,
                             status: thmhe_pkg::STATUS_OK};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         map_w_ff     <= thmhe_pkg::MAP_SIDE_RESET;
         map_h_ff     <= thmhe_pkg::MAP_SIDE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         map_w_ff     <= map_w_in;
         map_h_ff     <= map_h_in;
      end
      step_ff     <= step_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      h_ff        <= h_in;
      w_ff        <= w_in;
      a_ff        <= a_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      best_ff     <= best_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
